>>> rtl/core/i2cee_pkg.sv
// ----------------------------------------------------------------------------
// I2C EEPROM byte access master package
// Shared types, codes and the micro-program tables of the transfer sequencer.
// ----------------------------------------------------------------------------
package i2cee_pkg;

  // Field widths.
  localparam int unsigned KindW     = 2;
  localparam int unsigned AddrW     = 16;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 8;
  localparam int unsigned PosW      = 4;
  localparam int unsigned SubW      = 3;
  localparam int unsigned BitCntW   = 4;

  localparam int unsigned AddrBitsDefault = 16;

  // Command kinds; any other code is a plain tick.
  localparam logic [KindW-1:0] KindTick  = 2'd0;
  localparam logic [KindW-1:0] KindRead  = 2'd1;
  localparam logic [KindW-1:0] KindWrite = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgDelayTicks = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgStopRestart = 1'b1;

  localparam logic [ByteW-1:0] DelayTicksReset = 8'd11;
  localparam logic [ByteW-1:0] CtrlByteBase    = 8'hA0;

  typedef enum logic [3:0] {
    SegStart,
    SegCtrl,
    SegAckWait,
    SegAdHi,
    SegAck,
    SegAdLo,
    SegData,
    SegStop,
    SegOptStop,
    SegCtrlRd,
    SegRecv,
    SegNoAck,
    SegEnd
  } seg_e;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             page_select;
    logic [AddrW-1:0] mem_address;
    logic [ByteW-1:0] write_data;
    logic             sda_in;
  } cmd_t;

  typedef struct packed {
    logic [ByteW-1:0] delay_ticks;
    logic             stop_before_restart;
  } cfg_t;

  typedef struct packed {
    logic             scl_out;
    logic             sda_out;
    logic [ByteW-1:0] read_data;
    logic             done_res;
    logic             busy_res;
  } res_t;

  // Segment at a program position; position zero and anything past the end
  // of the program read as the end marker.
  function automatic seg_e seg_at(input logic is_read, input logic [PosW-1:0] pos);
    seg_e s;
    s = SegEnd;
    if (is_read) begin
      unique case (pos)
        4'd1:    s = SegStart;
        4'd2:    s = SegCtrl;
        4'd3:    s = SegAckWait;
        4'd4:    s = SegAdHi;
        4'd5:    s = SegAck;
        4'd6:    s = SegAdLo;
        4'd7:    s = SegAck;
        4'd8:    s = SegOptStop;
        4'd9:    s = SegStart;
        4'd10:   s = SegCtrlRd;
        4'd11:   s = SegAck;
        4'd12:   s = SegRecv;
        4'd13:   s = SegNoAck;
        4'd14:   s = SegStop;
        default: s = SegEnd;
      endcase
    end else begin
      unique case (pos)
        4'd1:    s = SegStart;
        4'd2:    s = SegCtrl;
        4'd3:    s = SegAckWait;
        4'd4:    s = SegAdHi;
        4'd5:    s = SegAck;
        4'd6:    s = SegAdLo;
        4'd7:    s = SegAck;
        4'd8:    s = SegData;
        4'd9:    s = SegAck;
        4'd10:   s = SegStop;
        default: s = SegEnd;
      endcase
    end
    return s;
  endfunction

endpackage

>>> rtl/core/i2cee_if.sv
// ----------------------------------------------------------------------------
// I2C EEPROM byte access master channels
// Command/tick input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface i2cee_cmd_if;
  logic                            valid;
  logic                            ready;
  logic [i2cee_pkg::KindW-1:0]     kind;
  logic                            page_select;
  logic [i2cee_pkg::AddrW-1:0]     mem_address;
  logic [i2cee_pkg::ByteW-1:0]     write_data;
  logic                            sda_in;

  modport source (output valid, kind, page_select, mem_address, write_data, sda_in,
                  input ready);
  modport sink   (input valid, kind, page_select, mem_address, write_data, sda_in,
                  output ready);
endinterface

interface i2cee_res_if;
  logic                            valid;
  logic                            ready;
  logic                            scl_out;
  logic                            sda_out;
  logic [i2cee_pkg::ByteW-1:0]     read_data;
  logic                            done_res;
  logic                            busy_res;

  modport source (output valid, scl_out, sda_out, read_data, done_res, busy_res,
                  input ready);
  modport sink   (input valid, scl_out, sda_out, read_data, done_res, busy_res,
                  output ready);
endinterface

interface i2cee_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [i2cee_pkg::CfgIdxW-1:0]     index;
  logic [i2cee_pkg::CfgDataW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/i2c_eeprom_byte_access_master_core.sv
// ----------------------------------------------------------------------------
// I2C EEPROM byte access master
// Bit-level I2C master for one random byte read or write to a serial EEPROM.
// ----------------------------------------------------------------------------
// Result: registered; a result beat is valid in the cycle after its input beat.
// Throughput: one beat per cycle; the sequencer state and the result register
// update on the same edge, so a new beat is taken in the cycle that the waiting
// result leaves, and the input stalls only while a result is held off.
// Reset: idle, SCL and SDA released high, delay_ticks 11, no stop before the
// repeated start, result register empty.
module i2c_eeprom_byte_access_master_core #(
  parameter int unsigned ADDR_BITS = i2cee_pkg::AddrBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  i2cee_cmd_if.sink  cmd_i,
  i2cee_res_if.source res_o,
  i2cee_cfg_if.sink  cfg_i
);

  i2cee_pkg::cfg_t cfg_q;
  i2cee_pkg::cmd_t cmd;
  i2cee_pkg::res_t res_next;
  i2cee_pkg::res_t res_q;
  logic            res_valid_q;
  logic            cmd_ready;
  logic            cmd_fire;

  assign cmd_ready   = !res_valid_q || res_o.ready;
  assign cmd_fire    = cmd_i.valid && cmd_ready;
  assign cmd_i.ready = cmd_ready;
  assign cfg_i.ready = 1'b1;

  assign cmd.kind        = cmd_i.kind;
  assign cmd.page_select = cmd_i.page_select;
  assign cmd.mem_address = cmd_i.mem_address;
  assign cmd.write_data  = cmd_i.write_data;
  assign cmd.sda_in      = cmd_i.sda_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delay_ticks         <= i2cee_pkg::DelayTicksReset;
      cfg_q.stop_before_restart <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        i2cee_pkg::CfgDelayTicks:  cfg_q.delay_ticks <= cfg_i.data;
        i2cee_pkg::CfgStopRestart: cfg_q.stop_before_restart <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  i2cee_seq #(
    .ADDR_BITS(ADDR_BITS)
  ) u_seq (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(cmd_fire),
    .cmd_i (cmd),
    .cfg_i (cfg_q),
    .res_o (res_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_ready) begin
      res_valid_q <= cmd_i.valid;
    end
  end

  // Result payload only moves when a new beat is taken.
  always_ff @(posedge clk_i) begin
    if (cmd_fire) begin
      res_q <= res_next;
    end
  end

  assign res_o.valid     = res_valid_q;
  assign res_o.scl_out   = res_q.scl_out;
  assign res_o.sda_out   = res_q.sda_out;
  assign res_o.read_data = res_q.read_data;
  assign res_o.done_res  = res_q.done_res;
  assign res_o.busy_res  = res_q.busy_res;

endmodule

>>> rtl/core/i2cee_seq.sv
// ----------------------------------------------------------------------------
// I2C EEPROM transfer sequencer
// Holds the transfer state and advances it by one tick per accepted beat.
// ----------------------------------------------------------------------------
module i2cee_seq #(
  parameter int unsigned ADDR_BITS = i2cee_pkg::AddrBitsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  i2cee_pkg::cmd_t   cmd_i,
  input  i2cee_pkg::cfg_t   cfg_i,
  output i2cee_pkg::res_t   res_o
);

  localparam logic [i2cee_pkg::AddrW-1:0] AddrMask =
    i2cee_pkg::AddrW'((32'd1 << ADDR_BITS) - 32'd1);
  localparam bit ShortAddr = (ADDR_BITS <= 8);

  logic [i2cee_pkg::PosW-1:0]    step_q, step_d;
  logic [i2cee_pkg::SubW-1:0]    sub_q, sub_d;
  logic [i2cee_pkg::BitCntW-1:0] bit_q, bit_d;
  logic [i2cee_pkg::ByteW-1:0]   wait_q, wait_d;
  logic [i2cee_pkg::ByteW-1:0]   shift_q, shift_d;
  logic [i2cee_pkg::AddrW-1:0]   addr_q, addr_d;
  logic [i2cee_pkg::ByteW-1:0]   data_q, data_d;
  logic                          page_q, page_d;
  logic                          read_q, read_d;
  logic                          scl_q, scl_d;
  logic                          sda_q, sda_d;
  logic [i2cee_pkg::ByteW-1:0]   recv_q, recv_d;
  logic                          done;

  logic [i2cee_pkg::ByteW-1:0]   reload;
  logic [i2cee_pkg::ByteW-1:0]   wait_dec;
  logic [i2cee_pkg::ByteW-1:0]   ctrl_byte;
  logic [i2cee_pkg::BitCntW-1:0] bit_inc;
  i2cee_pkg::seg_e               seg_cur;

  assign reload    = (cfg_i.delay_ticks == '0) ? i2cee_pkg::ByteW'(1) : cfg_i.delay_ticks;
  assign wait_dec  = (wait_q != '0) ? wait_q - i2cee_pkg::ByteW'(1) : '0;
  assign ctrl_byte = i2cee_pkg::CtrlByteBase | {6'b0, page_q, 1'b0};
  assign bit_inc   = bit_q + i2cee_pkg::BitCntW'(1);
  assign seg_cur   = i2cee_pkg::seg_at(read_q, step_q);

  always_comb begin
    logic                       run;
    logic                       fin;
    logic                       adv;
    logic [i2cee_pkg::PosW-1:0] pos_a, pos_b, pos_c;
    i2cee_pkg::seg_e            seg_a, seg_b, seg_c;

    step_d  = step_q;
    sub_d   = sub_q;
    bit_d   = bit_q;
    wait_d  = wait_q;
    shift_d = shift_q;
    addr_d  = addr_q;
    data_d  = data_q;
    page_d  = page_q;
    read_d  = read_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    recv_d  = recv_q;
    done    = 1'b0;
    run     = 1'b0;
    fin     = 1'b0;
    adv     = 1'b1;
    pos_a   = step_q + i2cee_pkg::PosW'(1);
    seg_a   = i2cee_pkg::seg_at(read_q, pos_a);
    pos_b   = pos_a;
    seg_b   = seg_a;
    pos_c   = pos_a;
    seg_c   = seg_a;

    if (step_i) begin
      if (step_q == '0) begin
        if (cmd_i.kind == i2cee_pkg::KindRead || cmd_i.kind == i2cee_pkg::KindWrite) begin
          // The first micro-step of the start condition runs on this beat.
          addr_d = cmd_i.mem_address & AddrMask;
          data_d = cmd_i.write_data;
          page_d = cmd_i.page_select;
          read_d = (cmd_i.kind == i2cee_pkg::KindRead);
          step_d = i2cee_pkg::PosW'(1);
          sub_d  = i2cee_pkg::SubW'(1);
          bit_d  = '0;
          scl_d  = 1'b1;
          wait_d = reload;
        end
      end else begin
        wait_d = wait_dec;
        if (wait_dec == '0) begin
          if (seg_cur == i2cee_pkg::SegEnd) begin
            step_d = '0;
            sub_d  = '0;
            done   = 1'b1;
          end else begin
            run    = 1'b1;
            wait_d = reload;
          end
        end
      end
    end

    if (run) begin
      case (seg_cur)
        i2cee_pkg::SegStart: begin
          if (sub_q == 3'd0) begin
            scl_d = 1'b1;
          end else if (sub_q == 3'd1) begin
            sda_d = 1'b0;
          end else begin
            scl_d = 1'b0;
            fin   = 1'b1;
          end
        end
        i2cee_pkg::SegCtrl, i2cee_pkg::SegCtrlRd, i2cee_pkg::SegAdHi,
        i2cee_pkg::SegAdLo, i2cee_pkg::SegData: begin
          if (sub_q == 3'd0) begin
            sda_d = shift_q[7];
            scl_d = 1'b1;
          end else if (sub_q == 3'd1) begin
            scl_d   = 1'b0;
            shift_d = {shift_q[6:0], 1'b0};
            bit_d   = bit_inc;
            sub_d   = (bit_inc < 4'd8) ? 3'd0 : 3'd2;
            adv     = 1'b0;
          end else begin
            fin = 1'b1;
          end
        end
        i2cee_pkg::SegAck, i2cee_pkg::SegAckWait: begin
          if (sub_q == 3'd0) begin
            scl_d = 1'b0;
          end else if (sub_q == 3'd1) begin
            sda_d = 1'b1;
          end else if (sub_q == 3'd2) begin
            scl_d = 1'b1;
          end else if (sub_q == 3'd3) begin
            bit_d = {3'b0, cmd_i.sda_in};
          end else begin
            scl_d = 1'b0;
            // The ack after the first control byte is polled until SDA is low.
            if (seg_cur == i2cee_pkg::SegAckWait && bit_q != '0) begin
              sub_d = '0;
              adv   = 1'b0;
            end else begin
              fin = 1'b1;
            end
          end
        end
        i2cee_pkg::SegRecv: begin
          if (sub_q == 3'd0) begin
            scl_d = 1'b1;
          end else if (sub_q == 3'd1) begin
            shift_d = {shift_q[6:0], cmd_i.sda_in};
          end else if (sub_q == 3'd2) begin
            scl_d = 1'b0;
            bit_d = bit_inc;
            sub_d = (bit_inc < 4'd8) ? 3'd0 : 3'd3;
            adv   = 1'b0;
          end else begin
            recv_d = shift_q;
            fin    = 1'b1;
          end
        end
        i2cee_pkg::SegNoAck: begin
          if (sub_q == 3'd0) begin
            sda_d = 1'b1;
            scl_d = 1'b1;
          end else begin
            scl_d = 1'b0;
            sda_d = 1'b1;
            fin   = 1'b1;
          end
        end
        i2cee_pkg::SegStop, i2cee_pkg::SegOptStop: begin
          if (sub_q == 3'd0) begin
            sda_d = 1'b0;
          end else if (sub_q == 3'd1) begin
            scl_d = 1'b1;
          end else begin
            sda_d = 1'b1;
            fin   = 1'b1;
          end
        end
        default: begin
          adv = 1'b0;
        end
      endcase

      if (fin) begin
        // Enter the next segment, skipping the high address byte on short
        // addresses and the optional stop when it is not enabled.
        if (ShortAddr && seg_a == i2cee_pkg::SegAdHi) begin
          pos_b = pos_a + i2cee_pkg::PosW'(2);
        end
        seg_b = i2cee_pkg::seg_at(read_q, pos_b);
        pos_c = pos_b;
        if (seg_b == i2cee_pkg::SegOptStop && !cfg_i.stop_before_restart) begin
          pos_c = pos_b + i2cee_pkg::PosW'(1);
        end
        seg_c  = i2cee_pkg::seg_at(read_q, pos_c);
        step_d = pos_c;
        sub_d  = '0;
        bit_d  = '0;
        case (seg_c)
          i2cee_pkg::SegCtrl:   shift_d = ctrl_byte;
          i2cee_pkg::SegCtrlRd: shift_d = ctrl_byte | 8'h01;
          i2cee_pkg::SegAdHi:   shift_d = addr_q[15:8];
          i2cee_pkg::SegAdLo:   shift_d = addr_q[7:0];
          i2cee_pkg::SegData:   shift_d = data_q;
          i2cee_pkg::SegRecv:   shift_d = '0;
          default:              shift_d = shift_d;
        endcase
      end else if (adv) begin
        sub_d = sub_q + i2cee_pkg::SubW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      sub_q  <= '0;
      bit_q  <= '0;
      wait_q <= '0;
      scl_q  <= 1'b1;
      sda_q  <= 1'b1;
      recv_q <= '0;
      read_q <= 1'b0;
      page_q <= 1'b0;
    end else begin
      step_q <= step_d;
      sub_q  <= sub_d;
      bit_q  <= bit_d;
      wait_q <= wait_d;
      scl_q  <= scl_d;
      sda_q  <= sda_d;
      recv_q <= recv_d;
      read_q <= read_d;
      page_q <= page_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    addr_q  <= addr_d;
    data_q  <= data_d;
  end

  always_comb begin
    res_o.scl_out   = scl_d;
    res_o.sda_out   = sda_d;
    res_o.read_data = recv_d;
    res_o.done_res  = done;
    res_o.busy_res  = (step_d != '0);
  end

endmodule

>>> tb/tb_i2c_eeprom_byte_access_master_core.sv
// ----------------------------------------------------------------------------
// I2C EEPROM byte access master testbench
// Drives command and tick beats with random gaps, keeps a cycle-exact model of
// the SCL/SDA sequencer and checks every result beat against it, over several
// settings of the delay and the stop-before-restart option.
// ----------------------------------------------------------------------------
module tb_i2c_eeprom_byte_access_master_core;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cee_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned AddrBits = AddrBitsDefault;
  localparam logic [AddrW-1:0] AddrMask = AddrW'((32'd1 << AddrBits) - 32'd1);
  localparam logic [KindW-1:0] KindUnused = 2'd3;
  localparam int unsigned HoldTrigger = 150;
  localparam int unsigned HoldCycles = 400;

  localparam seg_e WrProg [10] = '{SegStart, SegCtrl, SegAckWait, SegAdHi, SegAck,
                                   SegAdLo, SegAck, SegData, SegAck, SegStop};
  localparam seg_e RdProg [14] = '{SegStart, SegCtrl, SegAckWait, SegAdHi, SegAck,
                                   SegAdLo, SegAck, SegOptStop, SegStart, SegCtrlRd,
                                   SegAck, SegRecv, SegNoAck, SegStop};

  logic clk_i;
  logic rst_ni;

  i2cee_cmd_if cmd_if ();
  i2cee_res_if res_if ();
  i2cee_cfg_if cfg_if ();

  i2c_eeprom_byte_access_master_core #(
    .ADDR_BITS(AddrBits)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .res_o (res_if),
    .cfg_i (cfg_if)
  );

  cmd_t        pending_beats[$];
  res_t        line_state_q[$];
  int unsigned err_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned result_cnt = 0;
  logic        cmd_fired = 1'b0;

  int send_gap = 0;
  int send_quiet = 0;
  int rcv_gap = 0;
  int rcv_quiet = 0;
  int hold_left = 0;
  bit hold_used = 1'b0;

  // Sequencer model state.
  logic [ByteW-1:0] cfg_delay;
  logic             cfg_stop;
  int               seq_pos;
  int               seq_sub;
  int               seq_bits;
  int               hold_cnt;
  logic [ByteW-1:0] shreg;
  logic [AddrW-1:0] lat_addr;
  logic [ByteW-1:0] lat_data;
  logic             lat_page;
  logic             lat_read;
  logic             scl_lvl;
  logic             sda_lvl;
  logic [ByteW-1:0] rx_byte;

  function automatic void clear_line_model();
    cfg_delay = DelayTicksReset;
    cfg_stop  = 1'b0;
    seq_pos   = 0;
    seq_sub   = 0;
    seq_bits  = 0;
    hold_cnt  = 0;
    shreg     = '0;
    lat_addr  = '0;
    lat_data  = '0;
    lat_page  = 1'b0;
    lat_read  = 1'b0;
    scl_lvl   = 1'b1;
    sda_lvl   = 1'b1;
    rx_byte   = '0;
  endfunction

  function automatic seg_e seg_of(int p);
    if (p < 1) return SegEnd;
    if (lat_read) return (p - 1 < 14) ? RdProg[p-1] : SegEnd;
    return (p - 1 < 10) ? WrProg[p-1] : SegEnd;
  endfunction

  // Move to the segment at seq_pos, skipping the ones this transfer leaves out.
  function automatic void enter_seg();
    seg_e             s;
    logic [ByteW-1:0] ctrl;
    ctrl = CtrlByteBase | {6'd0, lat_page, 1'b0};
    s = seg_of(seq_pos);
    while ((s == SegAdHi && AddrBits <= 8) || (s == SegOptStop && !cfg_stop)) begin
      seq_pos = seq_pos + ((s == SegAdHi) ? 2 : 1);
      s = seg_of(seq_pos);
    end
    seq_sub  = 0;
    seq_bits = 0;
    case (s)
      SegCtrl:   shreg = ctrl;
      SegCtrlRd: shreg = ctrl | 8'h01;
      SegAdHi:   shreg = lat_addr[15:8];
      SegAdLo:   shreg = lat_addr[7:0];
      SegData:   shreg = lat_data;
      SegRecv:   shreg = '0;
      default: ;
    endcase
  endfunction

  function automatic void run_micro(logic sda);
    seg_e s;
    bit   fin;
    s = seg_of(seq_pos);
    fin = 1'b0;
    case (s)
      SegStart: begin
        if (seq_sub == 0) scl_lvl = 1'b1;
        else if (seq_sub == 1) sda_lvl = 1'b0;
        else begin
          scl_lvl = 1'b0;
          fin = 1'b1;
        end
      end
      SegCtrl, SegCtrlRd, SegAdHi, SegAdLo, SegData: begin
        if (seq_sub == 0) begin
          sda_lvl = shreg[7];
          scl_lvl = 1'b1;
        end else if (seq_sub == 1) begin
          scl_lvl = 1'b0;
          shreg = {shreg[6:0], 1'b0};
          seq_bits++;
          seq_sub = (seq_bits < 8) ? 0 : 2;
          return;
        end else fin = 1'b1;
      end
      SegAck, SegAckWait: begin
        if (seq_sub == 0) scl_lvl = 1'b0;
        else if (seq_sub == 1) sda_lvl = 1'b1;
        else if (seq_sub == 2) scl_lvl = 1'b1;
        else if (seq_sub == 3) seq_bits = sda;
        else begin
          scl_lvl = 1'b0;
          // Only the ack after the first control byte is polled.
          if (s == SegAckWait && seq_bits != 0) begin
            seq_sub = 0;
            return;
          end
          fin = 1'b1;
        end
      end
      SegRecv: begin
        if (seq_sub == 0) scl_lvl = 1'b1;
        else if (seq_sub == 1) shreg = {shreg[6:0], sda};
        else if (seq_sub == 2) begin
          scl_lvl = 1'b0;
          seq_bits++;
          seq_sub = (seq_bits < 8) ? 0 : 3;
          return;
        end else begin
          rx_byte = shreg;
          fin = 1'b1;
        end
      end
      SegNoAck: begin
        if (seq_sub == 0) begin
          sda_lvl = 1'b1;
          scl_lvl = 1'b1;
        end else begin
          scl_lvl = 1'b0;
          sda_lvl = 1'b1;
          fin = 1'b1;
        end
      end
      SegStop, SegOptStop: begin
        if (seq_sub == 0) sda_lvl = 1'b0;
        else if (seq_sub == 1) scl_lvl = 1'b1;
        else begin
          sda_lvl = 1'b1;
          fin = 1'b1;
        end
      end
      default: return;
    endcase
    if (fin) begin
      seq_pos++;
      enter_seg();
    end else seq_sub++;
  endfunction

  function automatic res_t next_line_state(cmd_t c);
    res_t r;
    int   reload;
    bit   done;
    reload = (cfg_delay == 0) ? 1 : int'(cfg_delay);
    done = 1'b0;
    if (seq_pos == 0) begin
      if (c.kind == KindRead || c.kind == KindWrite) begin
        lat_addr = c.mem_address & AddrMask;
        lat_data = c.write_data;
        lat_page = c.page_select;
        lat_read = (c.kind == KindRead);
        seq_pos = 1;
        enter_seg();
        run_micro(c.sda_in);
        hold_cnt = reload;
      end
    end else begin
      if (hold_cnt > 0) hold_cnt--;
      if (hold_cnt == 0) begin
        if (seg_of(seq_pos) == SegEnd) begin
          seq_pos = 0;
          seq_sub = 0;
          done = 1'b1;
        end else begin
          run_micro(c.sda_in);
          hold_cnt = reload;
        end
      end
    end
    r.scl_out   = scl_lvl;
    r.sda_out   = sda_lvl;
    r.read_data = rx_byte;
    r.done_res  = done;
    r.busy_res  = (seq_pos != 0);
    return r;
  endfunction

  task automatic flag(string msg);
    if (err_cnt < 40) $display("ERROR @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic check_beat(res_t got, res_t want);
    if (got.scl_out !== want.scl_out)
      flag($sformatf("beat %0d scl_out %b, expected %b", result_cnt, got.scl_out,
                     want.scl_out));
    if (got.sda_out !== want.sda_out)
      flag($sformatf("beat %0d sda_out %b, expected %b", result_cnt, got.sda_out,
                     want.sda_out));
    if (got.read_data !== want.read_data)
      flag($sformatf("beat %0d read_data %h, expected %h", result_cnt, got.read_data,
                     want.read_data));
    if (got.done_res !== want.done_res)
      flag($sformatf("beat %0d done_res %b, expected %b", result_cnt, got.done_res,
                     want.done_res));
    if (got.busy_res !== want.busy_res)
      flag($sformatf("beat %0d busy_res %b, expected %b", result_cnt, got.busy_res,
                     want.busy_res));
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic void push_item(logic [KindW-1:0] kind, logic page, logic [AddrW-1:0] addr,
                                    logic [ByteW-1:0] data, logic sda);
    cmd_t c;
    c.kind        = kind;
    c.page_select = page;
    c.mem_address = addr;
    c.write_data  = data;
    c.sda_in      = sda;
    pending_beats.push_back(c);
  endfunction

  function automatic logic [AddrW-1:0] pick_addr();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return 16'h8000;
      default: return AddrW'($urandom);
    endcase
  endfunction

  // One command followed by roughly as many ticks as the transfer needs, with
  // a sprinkle of commands that land while the sequencer is busy.
  function automatic int queue_transfer(int dly, int room);
    int   ticks;
    int   hi_pct;
    int   r;
    logic is_rd;
    logic [KindW-1:0] k;
    is_rd = 1'($urandom_range(1));
    case ($urandom_range(2))
      0:       hi_pct = 5;
      1:       hi_pct = 20;
      default: hi_pct = 50;
    endcase
    push_item(is_rd ? KindRead : KindWrite, 1'($urandom_range(1)), pick_addr(),
              ByteW'($urandom_range(255)), 1'($urandom_range(99) < hi_pct));
    ticks = (is_rd ? 155 : 97) * ((dly == 0) ? 1 : dly) + int'($urandom_range(24)) - 12;
    if (ticks > room - 1) ticks = room - 1;
    for (int n = 0; n < ticks; n++) begin
      r = $urandom_range(99);
      if (r < 90) k = KindTick;
      else if (r < 94) k = KindUnused;
      else if (r < 97) k = KindRead;
      else k = KindWrite;
      push_item(k, 1'($urandom_range(1)), AddrW'($urandom), ByteW'($urandom),
                1'($urandom_range(99) < hi_pct));
    end
    return (ticks > 0) ? ticks + 1 : 1;
  endfunction

  function automatic int queue_noise();
    int cnt;
    cnt = $urandom_range(6, 1);
    for (int n = 0; n < cnt; n++)
      push_item(KindW'($urandom_range(3)), 1'($urandom_range(1)), AddrW'($urandom),
                ByteW'($urandom), 1'($urandom_range(1)));
    return cnt;
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_beats.size() != 0 || cmd_if.valid || line_state_q.size() != 0)
      @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Command and tick driver.
  always @(negedge clk_i) begin
    cmd_t nxt;
    if (rst_ni && (!cmd_if.valid || cmd_fired)) begin
      if (send_gap > 0 || pending_beats.size() == 0) begin
        if (send_gap > 0) send_gap--;
        cmd_if.valid <= 1'b0;
      end else begin
        nxt = pending_beats.pop_front();
        cmd_if.valid       <= 1'b1;
        cmd_if.kind        <= nxt.kind;
        cmd_if.page_select <= nxt.page_select;
        cmd_if.mem_address <= nxt.mem_address;
        cmd_if.write_data  <= nxt.write_data;
        cmd_if.sda_in      <= nxt.sda_in;
        if (send_quiet > 0) send_quiet--;
        else begin
          send_gap = pick_gap();
          if ($urandom_range(39) == 0) send_quiet = $urandom_range(80, 30);
        end
      end
    end
  end

  // Result receiver, with one long hold-off so that the block backs up.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (!hold_used && accepted_cnt >= HoldTrigger) begin
        hold_used = 1'b1;
        hold_left = HoldCycles;
        res_if.ready <= 1'b0;
      end else if (rcv_gap > 0) begin
        rcv_gap--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        if (rcv_quiet > 0) rcv_quiet--;
        else begin
          rcv_gap = pick_gap();
          if ($urandom_range(39) == 0) rcv_quiet = $urandom_range(80, 30);
        end
      end
    end
  end

  // Monitor: checks result beats, then predicts from the accepted input beat.
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    cmd_t c;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        got.scl_out   = res_if.scl_out;
        got.sda_out   = res_if.sda_out;
        got.read_data = res_if.read_data;
        got.done_res  = res_if.done_res;
        got.busy_res  = res_if.busy_res;
        if (line_state_q.size() == 0) flag($sformatf("beat %0d not expected", result_cnt));
        else begin
          want = line_state_q.pop_front();
          check_beat(got, want);
        end
        result_cnt++;
      end
      if (cmd_if.valid && cmd_if.ready) begin
        c.kind        = cmd_if.kind;
        c.page_select = cmd_if.page_select;
        c.mem_address = cmd_if.mem_address;
        c.write_data  = cmd_if.write_data;
        c.sda_in      = cmd_if.sda_in;
        line_state_q.push_back(next_line_state(c));
        accepted_cnt++;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          CfgDelayTicks:  cfg_delay = cfg_if.data;
          CfgStopRestart: cfg_stop  = cfg_if.data[0];
          default: ;
        endcase
      end
    end
    cmd_fired <= rst_ni && cmd_if.valid && cmd_if.ready;
  end

  initial begin : watchdog
    int unsigned n;
    n = 0;
    while (n < CycleLimit) begin
      @(posedge clk_i);
      n++;
    end
    $display("tb_i2c_eeprom_byte_access_master_core NOT OK");
    $finish;
  end

  initial begin
    int dly_tab[6]  = '{1, 1, 0, 2, 255, 1};
    bit stop_tab[6] = '{0, 1, 0, 1, 1, 0};
    int len_tab[6]  = '{170, 170, 100, 100, 30, 55};
    int n;
    cmd_if.valid       = 1'b0;
    cmd_if.kind        = KindTick;
    cmd_if.page_select = 1'b0;
    cmd_if.mem_address = '0;
    cmd_if.write_data  = '0;
    cmd_if.sda_in      = 1'b1;
    res_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = CfgDelayTicks;
    cfg_if.data        = '0;
    clear_line_model();
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed beats at the reset settings: idle ticks, a write with page, address
    // and data at their maximum, and commands that arrive while busy.
    push_item(KindUnused, 1'b0, '0, '0, 1'b1);
    push_item(KindTick, 1'b1, '1, '1, 1'b1);
    push_item(KindWrite, 1'b1, '1, '1, 1'b0);
    for (int i = 0; i < 8; i++) push_item(KindTick, 1'b0, '0, '0, 1'(i[0]));
    push_item(KindRead, 1'b0, '0, '0, 1'b0);
    push_item(KindUnused, 1'b1, 16'h8000, 8'h80, 1'b1);
    push_item(KindWrite, 1'b0, '0, '0, 1'b0);
    for (int i = 0; i < 11; i++) push_item(KindTick, 1'b1, '1, '1, 1'(i[1]));
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      write_reg(CfgDelayTicks, CfgDataW'(dly_tab[p]));
      write_reg(CfgStopRestart, {7'd0, stop_tab[p]});
      n = 0;
      while (n < len_tab[p]) begin
        if ($urandom_range(9) < 8) n += queue_transfer(dly_tab[p], len_tab[p] - n);
        else n += queue_noise();
      end
      wait_drained();
    end

    if (err_cnt == 0) $display("tb_i2c_eeprom_byte_access_master_core OK");
    else $display("tb_i2c_eeprom_byte_access_master_core NOT OK");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/i2cee_pkg.sv
rtl/core/i2cee_if.sv
rtl/core/i2cee_seq.sv
rtl/core/i2c_eeprom_byte_access_master_core.sv
tb/tb_i2c_eeprom_byte_access_master_core.sv
